// ===== hw/rtl/sha1v_pkg.sv =====
// Package: item types, command and status structs, and hash constants.
`default_nettype none
package sha1v_pkg;

   typedef struct packed {
      logic [7:0] message_byte;
      logic       byte_present;
      logic       last_item;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   localparam logic [31:0] IV0 = 32'h17452301;
   localparam logic [31:0] IV1 = 32'hEACDAF89;
   localparam logic [31:0] IV2 = 32'h98BFDCFE;
   localparam logic [31:0] IV3 = 32'h14325476;
   localparam logic [31:0] IV4 = 32'hC3D2C1F0;

   localparam logic [31:0] K0 = 32'h5A827901;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h1F1CBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   localparam int          DIGEST_WORDS = 5;
   localparam int          BLOCK_WORDS  = 16;
   localparam logic [6:0]  LAST_ROUND   = 7'd79;
   localparam logic [2:0]  LAST_INDEX   = 3'd4;
   localparam logic [5:0]  LEN_PREV_POS = 6'd55;
   localparam logic [5:0]  BLOCK_END    = 6'd63;

   typedef struct packed {
      logic       write_byte;
      logic       pad_first;
      logic       pad_fill;
      logic       work_init;
      logic       round_step;
      logic [6:0] round_idx;
      logic       cv_add;
      logic       cv_init;
      logic [2:0] out_idx;
   } cmd_type;

   typedef struct packed {
      logic pos_last;
      logic len_phase;
   } status_type;

endpackage
`default_nettype wire

// ===== hw/rtl/sha1v_datapath.sv =====
// Datapath: byte packing, message schedule, round logic and chaining words.
`default_nettype none
module sha1v_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sha1v_pkg::cmd_type   cmd,
   input  wire logic [7:0]           data_byte,
   output sha1v_pkg::status_type     status,
   output logic [31:0]               digest_word
);

   logic [31:0] cv_ff [sha1v_pkg::DIGEST_WORDS];
   logic [31:0] cv_in [sha1v_pkg::DIGEST_WORDS];
   logic [60:0] count_ff, count_in;
   logic [23:0] word_ff, word_in;
   logic [31:0] w_ff [sha1v_pkg::BLOCK_WORDS];
   logic [31:0] w_in [sha1v_pkg::BLOCK_WORDS];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [63:0] bits_ff, bits_in;
   logic        len_ff, len_in;

   logic [5:0]  pos;
   logic [7:0]  byte_val;
   logic [31:0] x_val, f_val, k_val, sched;

   assign pos                = count_ff[5:0];
   assign status.pos_last    = (pos == sha1v_pkg::BLOCK_END);
   assign status.len_phase   = len_ff;
   assign digest_word        = cv_ff[cmd.out_idx];

   always_comb begin
      if (cmd.pad_first) begin
         byte_val = 8'h80;
      end else if (cmd.pad_fill) begin
         byte_val = len_ff ? bits_ff[63:56] : 8'h00;
      end else begin
         byte_val = data_byte;
      end
   end

   always_comb begin
      sched = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      x_val = (cmd.round_idx < 7'd16) ? w_ff[0] : {sched[30:0], sched[31]};
      if (cmd.round_idx < 7'd20) begin
         f_val = (b_ff & (c_ff ^ d_ff)) ^ d_ff;
         k_val = sha1v_pkg::K0;
      end else if (cmd.round_idx < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1v_pkg::K1;
      end else if (cmd.round_idx < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = sha1v_pkg::K2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1v_pkg::K3;
      end
   end

   always_comb begin
      count_in = count_ff;
      word_in  = word_ff;
      bits_in  = bits_ff;
      len_in   = len_ff;
      for (int i = 0; i < sha1v_pkg::BLOCK_WORDS; i++) begin
         w_in[i] = w_ff[i];
      end
      for (int i = 0; i < sha1v_pkg::DIGEST_WORDS; i++) begin
         cv_in[i] = cv_ff[i];
      end
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;

      if (cmd.write_byte) begin
         count_in = count_ff + 61'd1;
         word_in  = {word_ff[15:0], byte_val};
         if (pos[1:0] == 2'd3) begin
            for (int i = 0; i < sha1v_pkg::BLOCK_WORDS - 1; i++) begin
               w_in[i] = w_ff[i + 1];
            end
            w_in[sha1v_pkg::BLOCK_WORDS - 1] = {word_ff, byte_val};
         end
      end
      if (cmd.pad_first) begin
         bits_in = {count_ff, 3'b000};
         len_in  = (pos == sha1v_pkg::LEN_PREV_POS);
      end
      if (cmd.pad_fill) begin
         if (len_ff) begin
            bits_in = {bits_ff[55:0], 8'h00};
         end
         len_in = len_ff | (pos == sha1v_pkg::LEN_PREV_POS);
      end
      if (cmd.round_step) begin
         for (int i = 0; i < sha1v_pkg::BLOCK_WORDS - 1; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[sha1v_pkg::BLOCK_WORDS - 1] = x_val;
         a_in = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + x_val;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
      end
      if (cmd.work_init) begin
         a_in = cv_ff[0];
         b_in = cv_ff[1];
         c_in = cv_ff[2];
         d_in = cv_ff[3];
         e_in = cv_ff[4];
      end
      if (cmd.cv_add) begin
         cv_in[0] = cv_ff[0] + a_ff;
         cv_in[1] = cv_ff[1] + b_ff;
         cv_in[2] = cv_ff[2] + c_ff;
         cv_in[3] = cv_ff[3] + d_ff;
         cv_in[4] = cv_ff[4] + e_ff;
      end
      if (cmd.cv_init) begin
         cv_in[0] = sha1v_pkg::IV0;
         cv_in[1] = sha1v_pkg::IV1;
         cv_in[2] = sha1v_pkg::IV2;
         cv_in[3] = sha1v_pkg::IV3;
         cv_in[4] = sha1v_pkg::IV4;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= sha1v_pkg::IV0;
         cv_ff[1] <= sha1v_pkg::IV1;
         cv_ff[2] <= sha1v_pkg::IV2;
         cv_ff[3] <= sha1v_pkg::IV3;
         cv_ff[4] <= sha1v_pkg::IV4;
         count_ff <= '0;
      end else begin
         for (int i = 0; i < sha1v_pkg::DIGEST_WORDS; i++) begin
            cv_ff[i] <= cv_in[i];
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      bits_ff <= bits_in;
      len_ff  <= len_in;
      for (int i = 0; i < sha1v_pkg::BLOCK_WORDS; i++) begin
         w_ff[i] <= w_in[i];
      end
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/sha1v_ctrl.sv =====
// Controller: sequences byte intake, padding, compression rounds and digest output.
`default_nettype none
module sha1v_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   byte_present,
   input  wire logic                   last_item,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [2:0]                  word_index,
   output logic                        last_word,
   output sha1v_pkg::cmd_type          cmd,
   input  wire sha1v_pkg::status_type  status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PADSTART,
      S_PAD,
      S_ROUND,
      S_FINAL,
      S_OUT
   } state_type;

   state_type   state_ff, resume_ff;
   logic        rsp_valid_ff;
   logic [6:0]  rnd_ff;
   logic [2:0]  idx_ff;
   logic        accept;

   assign req_stall  = (state_ff != S_IDLE);
   assign accept     = req_valid && (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign word_index = idx_ff;
   assign last_word  = (idx_ff == sha1v_pkg::LAST_INDEX);

   always_comb begin
      cmd            = '0;
      cmd.round_idx  = rnd_ff;
      cmd.out_idx    = idx_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.write_byte = accept && byte_present;
         end
         S_PADSTART: begin
            cmd.write_byte = 1'b1;
            cmd.pad_first  = 1'b1;
         end
         S_PAD: begin
            cmd.write_byte = 1'b1;
            cmd.pad_fill   = 1'b1;
         end
         S_ROUND: begin
            cmd.round_step = 1'b1;
         end
         S_FINAL: begin
            cmd.cv_add = 1'b1;
         end
         S_OUT: begin
            cmd.cv_init = !rsp_stall && (idx_ff == sha1v_pkg::LAST_INDEX);
         end
         default: begin
            cmd = '0;
         end
      endcase
      cmd.work_init = cmd.write_byte && status.pos_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         resume_ff    <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rnd_ff       <= '0;
         idx_ff       <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (byte_present && status.pos_last) begin
                     state_ff  <= S_ROUND;
                     rnd_ff    <= '0;
                     resume_ff <= last_item ? S_PADSTART : S_IDLE;
                  end else if (last_item) begin
                     state_ff <= S_PADSTART;
                  end
               end
            end
            S_PADSTART: begin
               if (status.pos_last) begin
                  state_ff  <= S_ROUND;
                  rnd_ff    <= '0;
                  resume_ff <= S_PAD;
               end else begin
                  state_ff <= S_PAD;
               end
            end
            S_PAD: begin
               if (status.pos_last) begin
                  state_ff  <= S_ROUND;
                  rnd_ff    <= '0;
                  resume_ff <= status.len_phase ? S_OUT : S_PAD;
               end
            end
            S_ROUND: begin
               rnd_ff <= rnd_ff + 7'd1;
               if (rnd_ff == sha1v_pkg::LAST_ROUND) begin
                  state_ff <= S_FINAL;
               end
            end
            S_FINAL: begin
               state_ff <= resume_ff;
               if (resume_ff == S_OUT) begin
                  rsp_valid_ff <= 1'b1;
                  idx_ff       <= '0;
               end
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  if (idx_ff == sha1v_pkg::LAST_INDEX) begin
                     state_ff     <= S_IDLE;
                     rsp_valid_ff <= 1'b0;
                     idx_ff       <= '0;
                  end else begin
                     idx_ff <= idx_ff + 3'd1;
                  end
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/sha1v_variant_top_note.sv =====
// Digest word selector: packs controller index and datapath word into the result item.
`default_nettype none
module sha1v_rsp_pack (
   input  wire logic [31:0]     digest_word,
   input  wire logic [2:0]      word_index,
   input  wire logic            last_word,
   output sha1v_pkg::rsp_type   rsp_data
);

   always_comb begin
      rsp_data.digest_word = digest_word;
      rsp_data.word_index  = (word_index > sha1v_pkg::LAST_INDEX) ?
                             sha1v_pkg::LAST_INDEX : word_index;
      rsp_data.last_word   = last_word;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/sha1_variant_hash.sv =====
// Top level: SHA-1 structured hash with altered constants over a byte stream.
//
//   channel   prefix  dir  handshake       payload
//   input     req_    in   valid / stall   req_type: message_byte, byte_present, last_item
//   result    rsp_    out  valid / stall   rsp_type: digest_word, word_index, last_word
//
// A data byte is written as it is taken; the byte that fills a 64-byte block starts a
// compression (80 rounds, one per cycle in the round unit, then a chaining-word fold).
// A last item pads one byte per cycle (up to 72 bytes, with one or two compressions)
// and then offers five digest words, one per cycle while rsp_stall is low.
// No item is taken from the end of an item's work until its last digest word leaves.
// Reset is synchronous, with no clearing pass.
`default_nettype none
module sha1_variant_hash (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire sha1v_pkg::req_type  req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output sha1v_pkg::rsp_type       rsp_data
);

   sha1v_pkg::cmd_type    cmd;
   sha1v_pkg::status_type status;
   logic [31:0]           digest_word;
   logic [2:0]            word_index;
   logic                  last_word;

   sha1v_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .byte_present (req_data.byte_present),
      .last_item    (req_data.last_item),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .word_index   (word_index),
      .last_word    (last_word),
      .cmd          (cmd),
      .status       (status)
   );

   sha1v_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_data.message_byte),
      .status      (status),
      .digest_word (digest_word)
   );

   sha1v_rsp_pack u_rsp_pack (
      .digest_word (digest_word),
      .word_index  (word_index),
      .last_word   (last_word),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/sha1v_checker.sv =====
// Checker: port-level properties of the hash block, bound to the top level.
`default_nettype none
module sha1v_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire sha1v_pkg::req_type  req_data,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire sha1v_pkg::rsp_type  rsp_data
);

   logic in_seen;
   assign in_seen = req_valid && (req_data.byte_present || !req_data.byte_present);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_no_intake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall || !in_seen)
      else $error("input item taken during digest output");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_word |=>
         rsp_valid && (rsp_data.word_index == 3'($past(rsp_data.word_index) + 3'd1)))
      else $error("digest word index did not advance");

   a_end_of_digest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.last_word |=> !rsp_valid)
      else $error("result offered after final digest word");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

endmodule

bind sha1_variant_hash sha1v_checker u_sha1v_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
